FILE: rtl/rgbc_pkg.sv
package rgbc_pkg;

    localparam int MAX_LINE_PIXELS = 1024;
    localparam int ADDR_W   = $clog2(MAX_LINE_PIXELS);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int LINE_W   = HEIGHT_W + 1;
    localparam int POS_W    = WIDTH_W + HEIGHT_W;
    localparam int P_W      = LINE_W + WIDTH_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    localparam logic [CFG_DATA_W-1:0] COEFF_TOP_RST    = 24'd16776959;
    localparam logic [CFG_DATA_W-1:0] COEFF_MID_RST    = 24'd0;
    localparam logic [CFG_DATA_W-1:0] COEFF_BOTTOM_RST = 24'd66049;
    localparam logic [WIDTH_W-1:0]    FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0]   FRAME_HEIGHT_RST = 16'd768;

    // per-channel sum range and divide-by-nine constants
    localparam int PROD_W = 17;
    localparam int SUM_W  = 21;
    localparam int ABS_W  = 20;
    localparam int SAT_LIMIT   = 2304;   // 9 * 256
    localparam int DIV9_RECIP  = 7282;   // round(2^16 / 9)
    localparam int DIV9_SHIFT  = 16;
    localparam int QIN_W       = 12;
    localparam int RECIP_W     = 13;

    typedef logic [2:0][7:0] rgb_t;            // [0] red, [1] green, [2] blue
    typedef logic [2:0][2:0][7:0] coeff_t;     // [row][col] signed bytes

    typedef struct packed {
        logic       mode;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } pix_out_t;

    typedef struct packed {
        rgb_t [8:0] tap;        // row-major 3x3 neighborhood, edges resolved
        logic       frame_end;
    } taps_t;

endpackage

FILE: rtl/rgbc_kernel.sv
module rgbc_kernel import rgbc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  coeff_t   coeff,
    input  logic     in_valid,
    output logic     in_ready,
    input  taps_t    in_taps,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data
);

    // products stage
    logic                             c_valid_reg;
    logic signed [2:0][8:0][PROD_W-1:0] c_prod_reg;
    logic signed [2:0][8:0][PROD_W-1:0] c_prod_next;
    logic                             c_end_reg;
    // sum / magnitude stage
    logic                    d_valid_reg;
    logic [2:0][ABS_W-1:0]   d_abs_reg;
    logic [2:0][ABS_W-1:0]   d_abs_next;
    logic                    d_end_reg;
    // result register
    logic                    m_valid_reg;
    pix_out_t                m_data_reg;
    logic [2:0][7:0]         m_chan_next;

    logic m_take, d_take, c_take;

    assign m_take   = !m_valid_reg || out_ready;
    assign d_take   = !d_valid_reg || m_take;
    assign c_take   = !c_valid_reg || d_take;
    assign in_ready = c_take;

    always_comb begin
        logic signed [7:0] cf;
        logic signed [8:0] px;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                cf = $signed(coeff[k / 3][k % 3]);
                px = $signed({1'b0, in_taps.tap[k][ch]});
                c_prod_next[ch][k] = cf * px;
            end
        end
    end

    // element selects of the packed product array are unsigned; re-sign them
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            for (int k = 0; k < 9; k++) begin
                acc = acc + SUM_W'($signed(c_prod_reg[ch][k]));
            end
            d_abs_next[ch] = acc[SUM_W-1] ? ABS_W'(-acc) : ABS_W'(acc);
        end
    end

    // floor(x / 9) by reciprocal; exact for x below the saturation limit
    always_comb begin
        logic [QIN_W+RECIP_W-1:0] q;
        for (int ch = 0; ch < 3; ch++) begin
            q = QIN_W'(d_abs_reg[ch]) * RECIP_W'(DIV9_RECIP);
            if (d_abs_reg[ch] >= ABS_W'(SAT_LIMIT)) begin
                m_chan_next[ch] = 8'd255;
            end else begin
                m_chan_next[ch] = q[DIV9_SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (c_take) begin
                c_valid_reg <= in_valid;
            end
            if (d_take) begin
                d_valid_reg <= c_valid_reg;
            end
            if (m_take) begin
                m_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_take && in_valid) begin
            c_prod_reg <= c_prod_next;
            c_end_reg  <= in_taps.frame_end;
        end
        if (d_take && c_valid_reg) begin
            d_abs_reg <= d_abs_next;
            d_end_reg <= c_end_reg;
        end
        if (m_take && d_valid_reg) begin
            m_data_reg.out_red   <= m_chan_next[0];
            m_data_reg.out_green <= m_chan_next[1];
            m_data_reg.out_blue  <= m_chan_next[2];
            m_data_reg.frame_end <= d_end_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

FILE: rtl/rgb_3x3_convolution_clamped.sv
// Channel   Direction  Handshake          Word
// -------   ---------  -----------------  ------------------------------------
// s_        in         s_valid / s_ready  pix_in_t: mode, in_red/green/blue
// m_        out        m_valid / m_ready  pix_out_t: out_red/green/blue, frame_end
// cfg_      in         cfg_wr_en          cfg_index selects register, cfg_wdata
//
// One word per clock sustained while m_ready is held high. A word is registered in
// the window stage (line store read data, window mux), then passes through three
// pipeline stages: products, sum/abs, divide-by-nine and saturate.
// Line stores are single-port-write / single-read RAMs; a same-column access
// in back-to-back words (one-pixel lines) is bypassed around the RAM.
// Reset (aresetn, sync, active low) clears counters, window and valids; the
// line stores are not cleared. A stall at m_ready backs up stage by stage.
module rgb_3x3_convolution_clamped import rgbc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pix_out_t              m_data
);

    // ---------------- configuration registers ----------------
    coeff_t              coeff_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg[0] <= COEFF_TOP_RST;
            coeff_reg[1] <= COEFF_MID_RST;
            coeff_reg[2] <= COEFF_BOTTOM_RST;
            width_reg    <= FRAME_WIDTH_RST;
            height_reg   <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COEFF_TOP:    coeff_reg[0] <= cfg_wdata;
                CFG_COEFF_MID:    coeff_reg[1] <= cfg_wdata;
                CFG_COEFF_BOTTOM: coeff_reg[2] <= cfg_wdata;
                CFG_FRAME_WIDTH:  width_reg    <= cfg_wdata[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: height_reg   <= cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position tracking at accept ----------------
    logic [ADDR_W-1:0] col_reg;
    logic [LINE_W-1:0] line_reg;
    logic [POS_W-1:0]  opos_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [POS_W-1:0]    total;
    logic                col_wrap;
    logic [ADDR_W-1:0]   col_a, col_b;
    logic [LINE_W-1:0]   line_a, line_b, row_c;
    logic [P_W-1:0]      pos_a, pos_b;
    logic [POS_W-1:0]    opos_b;
    logic                drain, new_frame, ignore, emit;
    logic [WIDTH_W-1:0]  col_inc;
    logic [ADDR_W-1:0]   col_next;
    logic [LINE_W-1:0]   line_next;
    logic                s_fire;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_LINE_PIXELS)) begin
            w_eff = WIDTH_W'(MAX_LINE_PIXELS);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        total = POS_W'(w_eff) * POS_W'(h_eff);

        // a column left beyond a narrowed width wraps to the next line
        col_wrap = WIDTH_W'(col_reg) >= w_eff;
        col_a    = col_wrap ? '0 : col_reg;
        line_a   = col_wrap ? line_reg + LINE_W'(1) : line_reg;
        pos_a    = P_W'(line_a) * P_W'(w_eff) + P_W'(col_a);

        drain     = s_data.mode;
        new_frame = !drain && (pos_a >= P_W'(total));
        ignore    = drain && ((pos_a < P_W'(total)) || (opos_reg >= total));

        col_b  = new_frame ? '0 : col_a;
        line_b = new_frame ? '0 : line_a;
        pos_b  = new_frame ? '0 : pos_a;
        opos_b = new_frame ? '0 : opos_reg;

        emit = (pos_b >= P_W'(w_eff) + P_W'(1)) && (opos_b < total);

        col_inc = WIDTH_W'(col_b) + WIDTH_W'(1);
        if (col_inc >= w_eff) begin
            col_next  = '0;
            line_next = line_b + LINE_W'(1);
        end else begin
            col_next  = col_inc[ADDR_W-1:0];
            line_next = line_b;
        end

        // center row of the output pixel
        row_c = (col_b == '0) ? line_b - LINE_W'(2) : line_b - LINE_W'(1);
    end

    // ---------------- window stage (B) ----------------
    logic              b_valid_reg, b_emit_reg;
    logic [ADDR_W-1:0] b_col_reg;
    rgb_t              b_pix_reg;
    logic              b_col_zero_reg, b_col_one_reg, b_wide_reg;
    logic              b_top_reg, b_bot_reg, b_end_reg;
    logic              b_byp_reg;
    rgb_t              b_byp_up_reg, b_byp_lo_reg;
    rgb_t              rd_up_reg, rd_lo_reg;

    rgb_t                  upper_mem [MAX_LINE_PIXELS];
    rgb_t                  lower_mem [MAX_LINE_PIXELS];
    rgb_t [2:0][2:0]       win_reg;     // [row][col]
    rgb_t [2:0][2:0]       win_shift;
    rgb_t [2:0][2:0]       win_sel;
    rgb_t                  up_px, lo_px;
    logic [2:0][1:0]       rsel, csel;
    taps_t                 k_taps;
    logic                  k_ready, b_fire;

    assign s_ready = !b_valid_reg || b_fire;
    assign s_fire  = s_valid && s_ready;
    assign b_fire  = b_valid_reg && (!b_emit_reg || k_ready);

    always_comb begin
        up_px = b_byp_reg ? b_byp_up_reg : rd_up_reg;
        lo_px = b_byp_reg ? b_byp_lo_reg : rd_lo_reg;
        for (int r = 0; r < 3; r++) begin
            win_shift[r][0] = win_reg[r][1];
            win_shift[r][1] = win_reg[r][2];
        end
        win_shift[0][2] = up_px;
        win_shift[1][2] = lo_px;
        win_shift[2][2] = b_pix_reg;
        // first column of a line: the result belongs to the previous line's
        // last pixel, computed before the window moves
        win_sel = b_col_zero_reg ? win_reg : win_shift;

        rsel[0] = b_top_reg ? 2'd1 : 2'd0;
        rsel[1] = 2'd1;
        rsel[2] = b_bot_reg ? 2'd1 : 2'd2;
        if (b_col_zero_reg) begin
            csel[0] = b_wide_reg ? 2'd1 : 2'd2;
            csel[1] = 2'd2;
            csel[2] = 2'd2;
        end else begin
            csel[0] = b_col_one_reg ? 2'd1 : 2'd0;
            csel[1] = 2'd1;
            csel[2] = 2'd2;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                k_taps.tap[i*3 + j] = win_sel[rsel[i]][csel[j]];
            end
        end
        k_taps.frame_end = b_end_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            line_reg    <= '0;
            opos_reg    <= '0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else begin
            if (s_fire) begin
                if (ignore) begin
                    col_reg  <= col_a;
                    line_reg <= line_a;
                end else begin
                    col_reg  <= col_next;
                    line_reg <= line_next;
                    opos_reg <= opos_b + POS_W'(emit);
                end
            end
            if (s_ready) begin
                b_valid_reg <= s_fire && !ignore;
            end
            if (b_fire) begin
                win_reg <= win_shift;
            end
        end
    end

    // line stores: write as the word leaves B, read as a word enters B
    always_ff @(posedge aclk) begin
        if (b_fire) begin
            upper_mem[b_col_reg] <= lo_px;
            lower_mem[b_col_reg] <= b_pix_reg;
        end
        if (s_fire && !ignore) begin
            rd_up_reg      <= upper_mem[col_b];
            rd_lo_reg      <= lower_mem[col_b];
            b_byp_reg      <= b_fire && (b_col_reg == col_b);
            b_byp_up_reg   <= lo_px;
            b_byp_lo_reg   <= b_pix_reg;
            b_emit_reg     <= emit;
            b_col_reg      <= col_b;
            b_pix_reg      <= drain ? '0 : {s_data.in_blue, s_data.in_green, s_data.in_red};
            b_col_zero_reg <= col_b == '0;
            b_col_one_reg  <= col_b == ADDR_W'(1);
            b_wide_reg     <= w_eff >= WIDTH_W'(2);
            b_top_reg      <= row_c == '0;
            b_bot_reg      <= row_c >= LINE_W'(h_eff - HEIGHT_W'(1));
            b_end_reg      <= opos_b == (total - POS_W'(1));
        end
    end

    // ---------------- arithmetic pipeline ----------------
    rgbc_kernel u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coeff     (coeff_reg),
        .in_valid  (b_valid_reg && b_emit_reg),
        .in_ready  (k_ready),
        .in_taps   (k_taps),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

FILE: rtl/rgbc_checker.sv
module rgbc_checker import rgbc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input pix_out_t m_data
);

    logic s_idle;
    assign s_idle = !(s_valid && s_ready) && m_ready;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed or dropped");

    // with no new words and an open sink, the pipeline empties
    a_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        s_idle ##1 s_idle ##1 s_idle ##1 s_idle ##1 s_idle |=> !m_valid)
        else $error("result appeared without an input word");

    // a result needs a word accepted before it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 4) || $past(m_valid))
        else $error("result out of step with the input");

endmodule

bind rgb_3x3_convolution_clamped rgbc_checker u_rgbc_checker (.*);

FILE: bench/rgb_3x3_convolution_clamped_tb.sv
`timescale 1ns / 1ps

import rgbc_pkg::*;

// Scoreboard: keeps its own copy of the line stores, window and raster position,
// predicts the filtered words from the accepted input words and checks the
// outgoing words in order against those predictions.
class conv_scoreboard;

    logic [23:0]     coeff_row [3];
    int unsigned     width_reg;
    int unsigned     height_reg;
    logic [23:0]     upper_line [MAX_LINE_PIXELS];
    logic [23:0]     lower_line [MAX_LINE_PIXELS];
    logic [23:0]     win [9];
    int unsigned     col_pos;
    int unsigned     line_pos;
    longint unsigned out_count;
    pix_out_t        expected_words [$];
    int              errors;
    int              accepted;

    function new();
        coeff_row[0] = COEFF_TOP_RST;
        coeff_row[1] = COEFF_MID_RST;
        coeff_row[2] = COEFF_BOTTOM_RST;
        width_reg    = 32'(FRAME_WIDTH_RST);
        height_reg   = 32'(FRAME_HEIGHT_RST);
        for (int i = 0; i < MAX_LINE_PIXELS; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        col_pos   = 0;
        line_pos  = 0;
        out_count = 0;
        errors    = 0;
        accepted  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_COEFF_TOP:    coeff_row[0] = val;
            CFG_COEFF_MID:    coeff_row[1] = val;
            CFG_COEFF_BOTTOM: coeff_row[2] = val;
            CFG_FRAME_WIDTH:  width_reg    = 32'(val[WIDTH_W-1:0]);
            CFG_FRAME_HEIGHT: height_reg   = 32'(val[HEIGHT_W-1:0]);
            default: ;
        endcase
    endfunction

    function int unsigned eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_LINE_PIXELS) return MAX_LINE_PIXELS;
        return width_reg;
    endfunction

    function int unsigned eff_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // true while the next pixel still belongs to the current frame
    function bit frame_open();
        int unsigned c, l;
        c = col_pos;
        l = line_pos;
        if (c >= eff_w()) begin
            c = 0;
            l++;
        end
        return (longint'(l) * eff_w() + c) < longint'(eff_w()) * eff_h();
    endfunction

    function bit needs_drain();
        return !frame_open() && out_count < longint'(eff_w()) * eff_h();
    endfunction

    function void shift_in(logic [23:0] column [3]);
        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
            win[r*3 + 2] = column[r];
        end
    endfunction

    function logic [7:0] filter_channel(int rows [3], int cols [3], int sh);
        int sum;
        logic [23:0] px;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                px = win[rows[i]*3 + cols[j]];
                sum += int'($signed(coeff_row[i][j*8 +: 8])) * int'(px[sh +: 8]);
            end
        end
        if (sum < 0) sum = -sum;
        sum /= 9;
        if (sum > 255) sum = 255;
        return sum[7:0];
    endfunction

    function void note_word(pix_in_t d);
        int unsigned     w, h, c, l;
        longint unsigned total, p;
        logic [23:0]     pix;
        logic [23:0]     column [3];
        int              rows [3];
        int              cols [3];
        int              r;
        pix_out_t        res;
        accepted++;
        w     = eff_w();
        h     = eff_h();
        total = longint'(w) * h;
        pix   = '0;
        if (col_pos >= w) begin
            col_pos = 0;
            line_pos++;
        end
        p = longint'(line_pos) * w + col_pos;
        if (!d.mode) begin
            if (p >= total) begin
                // new frame; leftovers of the old one are dropped
                line_pos  = 0;
                col_pos   = 0;
                out_count = 0;
                p         = 0;
            end
            pix = {d.in_blue, d.in_green, d.in_red};
        end else if (p < total || out_count >= total) begin
            return;
        end
        c = col_pos;
        l = line_pos;
        column[0] = upper_line[c];
        column[1] = lower_line[c];
        column[2] = pix;
        upper_line[c] = lower_line[c];
        lower_line[c] = pix;
        if (c != 0) shift_in(column);
        if (p >= w + 1 && out_count < total) begin
            if (c == 0) begin
                r = l - 2;
                cols[0] = (w >= 2) ? 1 : 2;
                cols[1] = 2;
                cols[2] = 2;
            end else begin
                r = l - 1;
                cols[0] = (c == 1) ? 1 : 0;
                cols[1] = 1;
                cols[2] = 2;
            end
            rows[0] = (r == 0) ? 1 : 0;
            rows[1] = 1;
            rows[2] = (r >= int'(h) - 1) ? 1 : 2;
            res.out_red   = filter_channel(rows, cols, 0);
            res.out_green = filter_channel(rows, cols, 8);
            res.out_blue  = filter_channel(rows, cols, 16);
            res.frame_end = (out_count == total - 1);
            out_count++;
            expected_words.push_back(res);
        end
        if (c == 0) shift_in(column);
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos  = 0;
            line_pos = l + 1;
        end
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    function void check_word(pix_out_t got);
        pix_out_t exp_w;
        if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            return;
        end
        exp_w = expected_words.pop_front();
        compare_field("out_red",   exp_w.out_red,   got.out_red);
        compare_field("out_green", exp_w.out_green, got.out_green);
        compare_field("out_blue",  exp_w.out_blue,  got.out_blue);
        compare_field("frame_end", exp_w.frame_end, got.frame_end);
    endfunction
endclass

module rgb_3x3_convolution_clamped_tb;
    import rgbc_pkg::*;

    localparam int RANDOM_WORDS = 1550;    // input words for the whole run
    localparam int WIDE_PIXELS  = MAX_LINE_PIXELS + 24;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE       = 12;      // pipeline latency plus margin

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_COEFF_TOP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    pix_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    pix_out_t              m_data;

    conv_scoreboard sb = new();
    bit             no_idle = 1'b0;    // stretches with back-to-back traffic
    int             stall_left = 0;
    int             cycles = 0;

    rgb_3x3_convolution_clamped dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // Output side: random backpressure after every accepted word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_data);
            stall_left = draw_gap();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One input word: optional gap, then hold valid until accepted.
    task automatic send_word(pix_in_t d);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(d);
    endtask

    function automatic logic [7:0] rand_level();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pix_in_t d;
        d.mode     = 1'b0;
        d.in_red   = r;
        d.in_green = g;
        d.in_blue  = b;
        send_word(d);
    endtask

    task automatic send_random_pixel();
        send_pixel(rand_level(), rand_level(), rand_level());
    endtask

    // Drain word; the color bits are don't-care, so randomize them.
    task automatic send_drain();
        pix_in_t d;
        d.mode     = 1'b1;
        d.in_red   = 8'($urandom);
        d.in_green = 8'($urandom);
        d.in_blue  = 8'($urandom);
        send_word(d);
    endtask

    task automatic flush_frame();
        while (sb.frame_open()) send_random_pixel();
        while (sb.needs_drain()) send_drain();
    endtask

    // Registers change only with the pipe empty.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [23:0] top, logic [23:0] mid, logic [23:0] bot,
                              logic [23:0] w, logic [23:0] h);
        wait_idle();
        write_reg(CFG_COEFF_TOP, top);
        write_reg(CFG_COEFF_MID, mid);
        write_reg(CFG_COEFF_BOTTOM, bot);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [23:0] rand_coeffs();
        case ($urandom_range(0, 5))
            0:       return 24'h7F7F7F;        // max positive, saturates
            1:       return 24'h808080;        // most negative
            2:       return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase();
        int w, h, frames;
        w = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        if ($urandom_range(0, 15) == 0) w = 0;
        h = $urandom_range(1, 6);
        if ($urandom_range(0, 15) == 0) h = 0;
        set_config(rand_coeffs(), rand_coeffs(), rand_coeffs(), 24'(w), 24'(h));
        no_idle = ($urandom_range(0, 3) == 0);
        frames = $urandom_range(1, 3);
        repeat (frames) begin
            case ($urandom_range(0, 9))
                0: begin
                    // truncated frame; early drains must be ignored
                    repeat ($urandom_range(1, 4)) if (sb.frame_open()) send_random_pixel();
                    repeat ($urandom_range(1, 3)) send_drain();
                    while (sb.frame_open()) send_random_pixel();
                end
                1: begin
                    // full frame, no drain: next frame drops the tail
                    while (sb.frame_open()) send_random_pixel();
                    send_random_pixel();
                end
                2: begin
                    flush_frame();
                    repeat ($urandom_range(1, 3)) send_drain();
                end
                default: flush_frame();
            endcase
        end
        flush_frame();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // saturating 3x3 frame with full-scale pixels
        set_config(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'd3, 24'd3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, 8'hFF, (i == 4) ? 8'h00 : 8'hFF);
        flush_frame();
        // most negative coefficients, single-pixel frame, extra drain ignored
        set_config(24'h808080, 24'h808080, 24'h808080, 24'd1, 24'd1);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        flush_frame();
        send_drain();
        // width zero and height zero act as one
        set_config(24'hFF01FF, 24'h027F02, 24'h80FE80, 24'd0, 24'd0);
        send_pixel(8'h80, 8'h7F, 8'h01);
        flush_frame();
        // drain before frame end is ignored; new pixel after frame drops tail
        set_config(24'h010203, 24'hFD0405, 24'hFF0180, 24'd2, 24'd2);
        send_pixel(8'h12, 8'h34, 8'h56);
        send_drain();
        send_pixel(8'hFE, 8'h01, 8'h80);
        send_pixel(8'h00, 8'hFF, 8'h7F);
        send_pixel(8'hAA, 8'h55, 8'hC3);
        send_random_pixel();
        flush_frame();
        // one-line frame: the raster is past its end with all outputs given, so flush sends nothing
        set_config(24'hFFFEFF, 24'h000000, 24'h010201, 24'd4, 24'd1);
        flush_frame();

        // --- random part ---
        while (sb.accepted < RANDOM_WORDS - WIDE_PIXELS - 40) random_phase();

        // widest line (oversize width acts as the maximum); two-line frame,
        // sent far enough into the second line to give results
        set_config(rand_coeffs(), rand_coeffs(), rand_coeffs(), 24'h7FF, 24'd2);
        no_idle = 1'b1;
        repeat (WIDE_PIXELS) send_random_pixel();
        no_idle = 1'b0;

        // tallest frame, only its first lines; nothing follows it
        set_config(rand_coeffs(), rand_coeffs(), rand_coeffs(),
                   24'($urandom_range(1, 3)), 24'hFFFF);
        repeat (40) send_random_pixel();

        // --- wind down ---
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
